>>> hw/rtl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg: shared types and constants of the gyro bias calibrator
// Request codes, register indexes, controller-datapath structs and saturation.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam logic [1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [1:0] REQ_FORCE   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [1:0] CFG_INIT_SAMPLES    = 2'd0;
  localparam logic [1:0] CFG_STILL_SAMPLES   = 2'd1;
  localparam logic [1:0] CFG_STILL_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_EMA_ALPHA       = 2'd3;

  localparam logic [15:0] INIT_SAMPLES_RST    = 16'd400;
  localparam logic [15:0] STILL_SAMPLES_RST   = 16'd50;
  localparam logic [30:0] STILL_THRESHOLD_RST = 31'd32768;
  localparam logic [16:0] EMA_ALPHA_RST       = 17'd655;

  localparam int unsigned DIV_STEPS = 48;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic capture;
    logic accum;
    logic clear;
    logic set_running;
    logic diff_load;
    logic still_inc;
    logic still_clear;
    logic mul_load;
    logic ema_apply;
    logic div_start;
    logic bias_from_div;
    logic out_load;
  } gbc_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       running;
    logic       init_done;
    logic       has_samples;
    logic       is_still;
    logic       still_done;
    logic       div_done;
  } gbc_sts_t;

  function automatic logic [31:0] sat32(input logic [35:0] v);
    logic [31:0] r;
    if (v[35:31] != {5{v[35]}}) begin
      r = v[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/gbc_div.sv
// ----------------------------------------------------------------------------
// gbc_div: serial signed-by-unsigned divider
// Restoring division of a 48-bit signed sum by a 16-bit count, one quotient
// bit per cycle, with the quotient truncated toward zero.
// ----------------------------------------------------------------------------
module gbc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] dividend_i,
  input  logic [15:0]        divisor_i,
  output logic               done_o,
  output logic signed [31:0] quotient_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [gbc_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                           neg_q, neg_d;
  logic [16:0]                    rem_q, rem_d;
  logic [47:0]                    quo_q, quo_d;
  logic [15:0]                    dvs_q, dvs_d;
  logic [16:0]                    rem_shift;
  logic                           last;
  logic [31:0]                    mag32;

  assign rem_shift = {rem_q[15:0], quo_q[47]};
  assign last      = (cnt_q == gbc_pkg::DIV_CNT_W'(gbc_pkg::DIV_STEPS - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = dividend_i[47];
      rem_d  = '0;
      quo_d  = dividend_i[47] ? 48'(-dividend_i) : dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_shift >= {1'b0, dvs_q}) begin
        rem_d = rem_shift - {1'b0, dvs_q};
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = rem_shift;
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign mag32      = quo_q[31:0];
  assign done_o     = done_q;
  assign quotient_o = neg_q ? -mag32 : mag32;

endmodule

>>> hw/rtl/gbc_ctrl.sv
// ----------------------------------------------------------------------------
// gbc_ctrl: calibrator controller
// Sequences one request through the datapath and owns the output valid flag.
// ----------------------------------------------------------------------------
module gbc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  gbc_pkg::gbc_sts_t sts_i,
  output gbc_pkg::gbc_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_EMA  = 3'd3;
  localparam logic [2:0] S_DGO  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_OUT;
        unique case (sts_i.req)
          gbc_pkg::REQ_SAMPLE: begin
            if (!sts_i.running) begin
              cmd_o.accum = 1'b1;
              if (sts_i.init_done) begin
                state_d = S_DGO;
              end
            end else begin
              cmd_o.diff_load = 1'b1;
              state_d         = S_CHK;
            end
          end
          gbc_pkg::REQ_FORCE: begin
            if (!sts_i.running) begin
              if (sts_i.has_samples) begin
                state_d = S_DGO;
              end else begin
                cmd_o.set_running = 1'b1;
              end
            end
          end
          gbc_pkg::REQ_RESTART: begin
            cmd_o.clear = 1'b1;
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_CHK: begin
        state_d = S_OUT;
        if (sts_i.is_still) begin
          cmd_o.still_inc = 1'b1;
          if (sts_i.still_done) begin
            cmd_o.mul_load = 1'b1;
            state_d        = S_EMA;
          end
        end else begin
          cmd_o.still_clear = 1'b1;
        end
      end
      S_EMA: begin
        cmd_o.ema_apply = 1'b1;
        state_d         = S_OUT;
      end
      S_DGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.bias_from_div = 1'b1;
          cmd_o.set_running   = 1'b1;
          state_d             = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/gbc_datapath.sv
// ----------------------------------------------------------------------------
// gbc_datapath: calibrator datapath
// Holds the registers, the bias state, the stillness test, the EMA multiplier,
// the averaging divider and the output registers.
// ----------------------------------------------------------------------------
module gbc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [30:0]       cfg_data_i,
  input  logic [1:0]        req_type_i,
  input  logic [31:0]       raw_rate_i,
  input  gbc_pkg::gbc_cmd_t cmd_i,
  output gbc_pkg::gbc_sts_t sts_o,
  output logic [31:0]       bias_value_o,
  output logic [31:0]       corrected_rate_o,
  output logic              is_calibrated_o
);

  logic [15:0]        init_samples_q;
  logic [15:0]        still_samples_q;
  logic [30:0]        still_threshold_q;
  logic [16:0]        ema_alpha_q;

  logic signed [31:0] bias_q, bias_d;
  logic signed [47:0] sum_q, sum_d;
  logic [15:0]        count_q, count_d;
  logic [15:0]        still_q, still_d;
  logic               running_q, running_d;

  logic [1:0]         req_q;
  logic signed [31:0] raw_q;
  logic signed [32:0] diff_q;
  logic signed [50:0] prod_q;
  logic [31:0]        bias_out_q;
  logic [31:0]        corr_out_q;
  logic               cal_out_q;

  logic [15:0]        count_inc;
  logic [15:0]        still_inc;
  logic [32:0]        diff_mag;
  logic signed [17:0] alpha_s;
  logic signed [50:0] prod_full;
  logic signed [34:0] step_floor;
  logic [35:0]        ema_sum;
  logic [35:0]        corr_wide;
  logic               div_done;
  logic signed [31:0] div_quo;

  gbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_samples_q    <= gbc_pkg::INIT_SAMPLES_RST;
      still_samples_q   <= gbc_pkg::STILL_SAMPLES_RST;
      still_threshold_q <= gbc_pkg::STILL_THRESHOLD_RST;
      ema_alpha_q       <= gbc_pkg::EMA_ALPHA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbc_pkg::CFG_INIT_SAMPLES:    init_samples_q    <= cfg_data_i[15:0];
        gbc_pkg::CFG_STILL_SAMPLES:   still_samples_q   <= cfg_data_i[15:0];
        gbc_pkg::CFG_STILL_THRESHOLD: still_threshold_q <= cfg_data_i;
        gbc_pkg::CFG_EMA_ALPHA:       ema_alpha_q       <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  assign count_inc  = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;
  assign still_inc  = (still_q == 16'hFFFF) ? still_q : still_q + 16'd1;
  assign diff_mag   = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
  assign alpha_s    = {1'b0, ema_alpha_q};
  assign prod_full  = alpha_s * diff_q;
  assign step_floor = prod_q[50:16];
  assign ema_sum    = 36'(bias_q) + 36'(step_floor);
  assign corr_wide  = 36'(raw_q) - 36'(bias_q);

  always_comb begin
    bias_d    = bias_q;
    sum_d     = sum_q;
    count_d   = count_q;
    still_d   = still_q;
    running_d = running_q;
    if (cmd_i.clear) begin
      bias_d    = '0;
      sum_d     = '0;
      count_d   = '0;
      still_d   = '0;
      running_d = 1'b0;
    end
    if (cmd_i.accum) begin
      sum_d   = sum_q + 48'(raw_q);
      count_d = count_inc;
    end
    if (cmd_i.set_running) begin
      running_d = 1'b1;
    end
    if (cmd_i.still_inc) begin
      still_d = still_inc;
    end
    if (cmd_i.still_clear) begin
      still_d = '0;
    end
    if (cmd_i.bias_from_div) begin
      bias_d = div_quo;
    end
    if (cmd_i.ema_apply) begin
      bias_d = gbc_pkg::sat32(ema_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q    <= '0;
      sum_q     <= '0;
      count_q   <= '0;
      still_q   <= '0;
      running_q <= 1'b0;
    end else begin
      bias_q    <= bias_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
      still_q   <= still_d;
      running_q <= running_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      raw_q <= raw_rate_i;
    end
    if (cmd_i.diff_load) begin
      diff_q <= 33'(raw_q) - 33'(bias_q);
    end
    if (cmd_i.mul_load) begin
      prod_q <= prod_full;
    end
    if (cmd_i.out_load) begin
      bias_out_q <= bias_q;
      corr_out_q <= gbc_pkg::sat32(corr_wide);
      cal_out_q  <= running_q;
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.req         = req_q;
    sts_o.running     = running_q;
    sts_o.init_done   = (count_inc >= init_samples_q);
    sts_o.has_samples = (count_q != 16'd0);
    sts_o.is_still    = (diff_mag < {2'b00, still_threshold_q});
    sts_o.still_done  = (still_inc >= still_samples_q);
    sts_o.div_done    = div_done;
  end

  assign bias_value_o     = bias_out_q;
  assign corrected_rate_o = corr_out_q;
  assign is_calibrated_o  = cal_out_q;

endmodule

>>> hw/rtl/gyro_bias_calibrator_top.sv
// ----------------------------------------------------------------------------
// gyro_bias_calibrator_top: zero-rate bias estimator for one gyro axis
// Each request (sample, force completion, restart) returns one result with
// the bias, the saturated corrected rate and the calibrated flag. A request
// passes idle, evaluate and output states; a running-phase sample adds a
// stillness check and, if the EMA update applies, an EMA state. A request
// ending the averaging phase waits on the 48-step serial divider that forms
// the average. One request is in work at a time; the next is accepted while
// the previous result still waits in the output register. The user must write
// registers through the plain write port only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module gyro_bias_calibrator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] raw_rate_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] bias_value_o,
  output logic [31:0] corrected_rate_o,
  output logic        is_calibrated_o
);

  gbc_pkg::gbc_cmd_t cmd;
  gbc_pkg::gbc_sts_t sts;

  gbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gbc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .raw_rate_i       (raw_rate_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .bias_value_o     (bias_value_o),
    .corrected_rate_o (corrected_rate_o),
    .is_calibrated_o  (is_calibrated_o)
  );

endmodule
